// ===== rtl/core/mss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants of the message slot scheduler
// Request and response payloads, the tick record passed from front to back,
// queue sizes and the fixed slot check table.
// ----------------------------------------------------------------------------
package mss_pkg;

   // Stamp store depth; slots at or above it never fire
   localparam int SLOT_DEPTH  = 16;
   localparam int STAMP_IDX_W = $clog2(SLOT_DEPTH);

   // Check table size and step counter width
   localparam int NUM_CHECKS  = 13;
   localparam int CHECK_IDX_W = $clog2(NUM_CHECKS);

   // Front tick queue and response queue sizes
   localparam int TICK_DEPTH  = 2;
   localparam int TICK_PTR_W  = $clog2(TICK_DEPTH);
   localparam int TICK_CNT_W  = $clog2(TICK_DEPTH + 1);
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = $clog2(RSP_DEPTH + 1);

   localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
   localparam int          PERIOD_W      = 14;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [31:0] last_heartbeat_ms;
      logic        download_busy;
   } req_type;

   typedef struct packed {
      logic [3:0] slot;
      logic       last_of_tick;
   } rsp_type;

   // Classified tick handed to the back end
   typedef struct packed {
      logic [31:0] now_ms;
      logic        gate_open;
   } tick_type;

   // Slot number checked at each step, in call order
   function automatic logic [3:0] check_slot(input logic [CHECK_IDX_W-1:0] idx);
      logic [3:0] s;
      case (idx)
         4'd0:    s = 4'd1;
         4'd1:    s = 4'd2;
         4'd2:    s = 4'd13;
         4'd3:    s = 4'd3;
         4'd4:    s = 4'd4;
         4'd5:    s = 4'd5;
         4'd6:    s = 4'd6;
         4'd7:    s = 4'd7;
         4'd8:    s = 4'd8;
         4'd9:    s = 4'd9;
         4'd10:   s = 4'd10;
         4'd11:   s = 4'd11;
         4'd12:   s = 4'd12;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

   // Period in ms of the slot checked at each step
   function automatic logic [PERIOD_W-1:0] check_period(input logic [CHECK_IDX_W-1:0] idx);
      logic [PERIOD_W-1:0] p;
      case (idx)
         4'd0:    p = 14'd1000;
         4'd1:    p = 14'd1000;
         4'd2:    p = 14'd10000;
         4'd3:    p = 14'd20;
         4'd4:    p = 14'd20;
         4'd5:    p = 14'd200;
         4'd6:    p = 14'd50;
         4'd7:    p = 14'd100;
         4'd8:    p = 14'd200;
         4'd9:    p = 14'd1000;
         4'd10:   p = 14'd20;
         4'd11:   p = 14'd500;
         4'd12:   p = 14'd500;
         default: p = 14'd0;
      endcase
      return p;
   endfunction

   // Steps from 3 onward need an open link gate
   function automatic logic check_gated(input logic [CHECK_IDX_W-1:0] idx);
      return (idx >= 4'd3);
   endfunction

endpackage

// ===== rtl/core/multirate_message_slot_scheduler.sv =====
// Flow: an accepted request is registered in the tick queue, offered to the
//   sequencer in the next cycle and taken once the sequencer is idle or
//   flushing; each firing slot is held back until the next one or the end of
//   the tick is found, then pushed into the response queue, the last marked.
// Throughput: the sequencer checks one slot stamp per cycle (13 checks) while
//   the response queue is not full, and takes the next tick as it releases the last.
// Reset: synchronous, active high; clears all slot stamps to zero, sets the link
//   timeout to 3000 ms and empties both queues.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multirate_message_slot_scheduler: top level
// Front end classifies ticks into a short queue, back end walks the slot
// table and fills the response queue; holds the link timeout register.
// ----------------------------------------------------------------------------
module multirate_message_slot_scheduler (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  mss_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output mss_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data
);

   logic [15:0]       timeout_ff;
   logic              tick_valid;
   logic              tick_take;
   mss_pkg::tick_type tick_data;
   logic              back_push;
   logic              rsp_q_full;
   mss_pkg::rsp_type  back_rsp;

   // Hold the link timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= mss_pkg::TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   mss_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data        (req_data),
      .link_timeout_ms (timeout_ff),
      .tick_valid      (tick_valid),
      .tick_take       (tick_take),
      .tick_data       (tick_data)
   );

   mss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tick_valid (tick_valid),
      .tick_take  (tick_take),
      .tick_data  (tick_data),
      .rsp_push   (back_push),
      .rsp_full   (rsp_q_full),
      .rsp_data   (back_rsp)
   );

   mss_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_rsp),
      .full      (rsp_q_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // Sequencer never pushes into a full response queue
   assert property (@(posedge clock) disable iff (reset) back_push |-> !rsp_q_full)
      else $error("response pushed while queue full");

   // Sequencer takes a tick only when one is queued
   assert property (@(posedge clock) disable iff (reset) tick_take |-> tick_valid)
      else $error("tick taken from empty queue");

   // Every presented response names a real slot
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.slot >= 4'd1 && rsp_data.slot <= 4'd13))
      else $error("response slot out of range");
`endif

endmodule

// ===== rtl/core/mss_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_front: request intake and link classification
// Computes the heartbeat age against the timeout, folds it with the download
// flag into one gate bit and queues the tick for the back end.
// ----------------------------------------------------------------------------
module mss_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  mss_pkg::req_type req_data,
   input  logic [15:0]      link_timeout_ms,
   output logic             tick_valid,
   input  logic             tick_take,
   output mss_pkg::tick_type tick_data
);

   mss_pkg::tick_type                      queue_ff [mss_pkg::TICK_DEPTH];
   logic [mss_pkg::TICK_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [mss_pkg::TICK_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [mss_pkg::TICK_CNT_W-1:0]         count_ff, count_in;
   logic [31:0]                            link_age;
   logic                                   do_push;
   logic                                   do_pop;
   mss_pkg::tick_type                      tick_new;

   // Classify the incoming request
   assign link_age           = req_data.now_ms - req_data.last_heartbeat_ms;
   assign tick_new.now_ms    = req_data.now_ms;
   assign tick_new.gate_open = !req_data.download_busy && (link_age <= 32'(link_timeout_ms));

   assign req_full   = (count_ff == mss_pkg::TICK_CNT_W'(mss_pkg::TICK_DEPTH));
   assign tick_valid = (count_ff != '0);
   assign tick_data  = queue_ff[rd_ptr_ff];
   assign do_push    = req_push && !req_full;
   assign do_pop     = tick_take && tick_valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + (do_push ? 1'b1 : 1'b0);
      rd_ptr_in = rd_ptr_ff + (do_pop ? 1'b1 : 1'b0);
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the tick payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= tick_new;
      end
   end

endmodule

// ===== rtl/core/mss_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_back: slot check sequencer
// Walks the check table one step per cycle while the response queue has room,
// compares elapsed time against each slot period, restamps firing slots and
// emits one response each, holding the newest until the tick's last is known.
// ----------------------------------------------------------------------------
module mss_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              tick_valid,
   output logic              tick_take,
   input  mss_pkg::tick_type tick_data,
   output logic              rsp_push,
   input  logic              rsp_full,
   output mss_pkg::rsp_type  rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FLUSH
   } state_type;

   state_type                          state_ff, state_in;
   logic [mss_pkg::CHECK_IDX_W-1:0]    step_ff, step_in;
   mss_pkg::tick_type                  tick_ff, tick_in;
   logic                               pend_vld_ff, pend_vld_in;
   logic [3:0]                         pend_slot_ff, pend_slot_in;
   logic [31:0]                        stamp_ff [mss_pkg::SLOT_DEPTH];

   logic [3:0]                         cur_slot;
   logic [mss_pkg::STAMP_IDX_W-1:0]    cur_idx;
   logic                               cur_enabled;
   logic [31:0]                        elapsed;
   logic                               fire;
   logic                               stamp_we;

   // Evaluate the current step
   assign cur_slot    = mss_pkg::check_slot(step_ff);
   assign cur_idx     = mss_pkg::STAMP_IDX_W'(cur_slot);
   assign cur_enabled = (!mss_pkg::check_gated(step_ff) || tick_ff.gate_open)
                        && (int'(cur_slot) < mss_pkg::SLOT_DEPTH);
   assign elapsed     = tick_ff.now_ms - stamp_ff[cur_idx];
   assign fire        = cur_enabled && (elapsed > 32'(mss_pkg::check_period(step_ff)));

   // Sequence steps, pending response and tick intake
   always_comb begin
      state_in              = state_ff;
      step_in               = step_ff;
      tick_in               = tick_ff;
      pend_vld_in           = pend_vld_ff;
      pend_slot_in          = pend_slot_ff;
      tick_take             = 1'b0;
      rsp_push              = 1'b0;
      rsp_data.slot         = pend_slot_ff;
      rsp_data.last_of_tick = 1'b0;
      stamp_we              = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (tick_valid) begin
               tick_take = 1'b1;
               tick_in   = tick_data;
               step_in   = '0;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!rsp_full) begin
               if (fire) begin
                  stamp_we     = 1'b1;
                  rsp_push     = pend_vld_ff;
                  pend_vld_in  = 1'b1;
                  pend_slot_in = cur_slot;
               end
               step_in = step_ff + 1'b1;
               if (step_ff == mss_pkg::CHECK_IDX_W'(mss_pkg::NUM_CHECKS - 1)) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!rsp_full) begin
               rsp_push              = pend_vld_ff;
               rsp_data.last_of_tick = 1'b1;
               pend_vld_in           = 1'b0;
               if (tick_valid) begin
                  tick_take = 1'b1;
                  tick_in   = tick_data;
                  step_in   = '0;
                  state_in  = ST_CHECK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_ff     <= '0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         step_ff     <= step_in;
         pend_vld_ff <= pend_vld_in;
      end
      tick_ff      <= tick_in;
      pend_slot_ff <= pend_slot_in;
   end

   // Hold slot stamps; restamp on fire
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mss_pkg::SLOT_DEPTH; i++) begin
            stamp_ff[i] <= '0;
         end
      end else if (stamp_we) begin
         stamp_ff[cur_idx] <= tick_ff.now_ms;
      end
   end

endmodule

// ===== rtl/core/mss_rsp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_rsp_fifo: response queue
// Small register queue that decouples the sequencer from the response
// consumer and presents the oldest response while not empty.
// ----------------------------------------------------------------------------
module mss_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mss_pkg::rsp_type push_data,
   output logic             full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output mss_pkg::rsp_type rsp_data
);

   mss_pkg::rsp_type                 queue_ff [mss_pkg::RSP_DEPTH];
   logic [mss_pkg::RSP_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [mss_pkg::RSP_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [mss_pkg::RSP_CNT_W-1:0]    count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full      = (count_ff == mss_pkg::RSP_CNT_W'(mss_pkg::RSP_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = rsp_pop && !rsp_empty;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + (do_push ? 1'b1 : 1'b0);
      rd_ptr_in = rd_ptr_ff + (do_pop ? 1'b1 : 1'b0);
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the response payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== bench/slot_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_checker: response checker for the message slot scheduler
// Watches the request, response and register ports, predicts the firing
// slots of every accepted tick from its own copy of the slot stamps and the
// link timeout, and compares each accepted response with the oldest one owed.
// ----------------------------------------------------------------------------
module slot_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  mss_pkg::req_type req_data,
   input  logic             rsp_empty,
   input  logic             rsp_pop,
   input  mss_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data,
   output int               fail_count,
   output int               slots_owed,
   output int               slots_seen
);

   localparam int          NUM_STEPS     = 13;
   localparam int          FIRST_GATED   = 3;
   localparam int          STAMP_SLOTS   = 16;
   localparam logic [15:0] TIMEOUT_START = 16'd3000;

   // Slot and period of each check step, step 0 in the low bits
   localparam logic [NUM_STEPS*4-1:0] STEP_SLOT = {
      4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3,
      4'd13, 4'd2, 4'd1
   };
   localparam logic [NUM_STEPS*14-1:0] STEP_PERIOD = {
      14'd500, 14'd500, 14'd20, 14'd1000, 14'd200, 14'd100, 14'd50,
      14'd200, 14'd20, 14'd20, 14'd10000, 14'd1000, 14'd1000
   };

   logic [31:0]      slot_stamp [STAMP_SLOTS];
   logic [15:0]      link_timeout;
   mss_pkg::rsp_type owed_slots [$];
   int               fails = 0;
   int               seen  = 0;

   always @(posedge clock) begin : track
      logic [31:0]      age;
      logic [31:0]      lapse;
      logic             gate_open;
      logic [3:0]       slot;
      logic [3:0]       fired [NUM_STEPS];
      int               n_fired;
      mss_pkg::rsp_type want;
      mss_pkg::rsp_type item;
      if (reset) begin
         for (int i = 0; i < STAMP_SLOTS; i++) slot_stamp[i] = '0;
         link_timeout = TIMEOUT_START;
         owed_slots.delete();
      end else begin
         // Compare the accepted response before adding new predictions
         if (rsp_pop && !rsp_empty) begin
            seen++;
            if (owed_slots.size() == 0) begin
               fails++;
               $display("%0t: unexpected response slot %0d last %0b, none owed",
                        $time, rsp_data.slot, rsp_data.last_of_tick);
            end else begin
               want = owed_slots.pop_front();
               if (rsp_data.slot !== want.slot) begin
                  fails++;
                  $display("%0t: slot mismatch, expected %0d, got %0d",
                           $time, want.slot, rsp_data.slot);
               end
               if (rsp_data.last_of_tick !== want.last_of_tick) begin
                  fails++;
                  $display("%0t: last_of_tick mismatch, expected %0b, got %0b",
                           $time, want.last_of_tick, rsp_data.last_of_tick);
               end
            end
         end

         // Walk the check table for the accepted tick and restamp fired slots
         if (req_push && !req_full) begin
            age       = req_data.now_ms - req_data.last_heartbeat_ms;
            gate_open = !req_data.download_busy && (age <= {16'd0, link_timeout});
            n_fired   = 0;
            for (int k = 0; k < NUM_STEPS; k++) begin
               slot = STEP_SLOT[k*4 +: 4];
               if ((k < FIRST_GATED || gate_open) && slot < STAMP_SLOTS) begin
                  lapse = req_data.now_ms - slot_stamp[slot];
                  if (lapse > {18'd0, STEP_PERIOD[k*14 +: 14]}) begin
                     slot_stamp[slot] = req_data.now_ms;
                     fired[n_fired]   = slot;
                     n_fired++;
                  end
               end
            end
            for (int j = 0; j < n_fired; j++) begin
               item.slot         = fired[j];
               item.last_of_tick = (j == n_fired - 1);
               owed_slots.push_back(item);
            end
         end

         // Track the register; a write applies from the next request on
         if (csr_wr_en) link_timeout = csr_wr_data;
      end
      fail_count <= fails;
      slots_owed <= owed_slots.size();
      slots_seen <= seen;
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the message slot scheduler
// Sends directed and random millisecond ticks through the request queue under
// several link timeouts, drains responses with random stalls and one long
// hold, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;

   localparam int MAX_GAP        = 16;
   localparam int RESET_CYCLES   = 12;
   localparam int DRAIN_CYCLES   = 60;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_TICK      = 100;
   localparam int PHASE_TICKS    = 56;
   localparam int NUM_PHASES     = 6;
   localparam int WATCHDOG_LIMIT = 4000;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_push    = 1'b0;
   logic             req_full;
   mss_pkg::req_type req_data    = '0;
   logic             rsp_empty;
   logic             rsp_pop     = 1'b0;
   mss_pkg::rsp_type rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [15:0]      csr_wr_data = '0;

   int               fail_count;
   int               slots_owed;
   int               slots_seen;
   int               ticks_sent  = 0;
   int               idle_cycles = 0;
   logic             send_burst  = 1'b0;
   logic [31:0]      tick_ms     = '0;

   always #4 clock = ~clock;

   multirate_message_slot_scheduler u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   slot_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .slots_owed  (slots_owed),
      .slots_seen  (slots_seen)
   );

   // Offer one tick request after a random gap (none in burst mode) and hold it until accepted
   task automatic send_tick(input logic [31:0] now, input logic [31:0] heartbeat,
                            input logic busy);
      int               gap;
      mss_pkg::req_type item;
      gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      item.now_ms            = now;
      item.last_heartbeat_ms = heartbeat;
      item.download_busy     = busy;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      ticks_sent++;
   endtask

   // Drop the request, drain every owed response, let the pipe empty, write
   task automatic set_timeout(input logic [15:0] value);
      req_push <= 1'b0;
      do @(posedge clock); while (slots_owed != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Stimulus
   initial begin : stimulus
      logic [15:0] link_limit;
      logic [31:0] age;
      int          pick;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed ticks under the reset timeout
      send_tick(32'd0, 32'd0, 1'b0);                  // nothing due yet
      send_tick(32'd1000, 32'd1000, 1'b0);            // fast slots, period edge
      send_tick(32'd1001, 32'd1001, 1'b0);            // one past the period
      send_tick(32'd10001, 32'd10001, 1'b1);          // download busy
      send_tick(32'd10030, 32'd7030, 1'b0);           // age equals timeout
      send_tick(32'd10060, 32'd7059, 1'b0);           // age one past timeout
      send_tick(32'd10061, 32'd10062, 1'b0);          // heartbeat in the future
      send_tick(32'd40000, 32'd40000, 1'b0);          // every slot fires
      send_tick(32'hFFFF_FFF0, 32'hFFFF_FFF0, 1'b0);
      send_tick(32'h0000_0010, 32'hFFFF_FFFF, 1'b0);  // elapsed across the wrap
      send_tick(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);

      // Directed ticks at the timeout extremes
      set_timeout(16'd0);
      send_tick(32'h8000_0000, 32'h8000_0000, 1'b0);
      send_tick(32'h8000_0100, 32'h8000_00FF, 1'b0);
      set_timeout(16'hFFFF);
      send_tick(32'h8000_0200, 32'h8000_0200 - 32'd65535, 1'b0);
      send_tick(32'h8000_0300, 32'h8000_0300 - 32'd65536, 1'b0);
      tick_ms = 32'h8000_0300;

      // Random phases, one timeout setting each
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       link_limit = 16'd3000;
            1:       link_limit = 16'd0;
            2:       link_limit = 16'hFFFF;
            3:       link_limit = 16'($urandom_range(1, 100));
            default: link_limit = 16'($urandom_range(0, 65535));
         endcase
         set_timeout(link_limit);
         send_burst = ($urandom_range(0, 2) == 0);
         if (p == 3) tick_ms = 32'hFFFF_F000;
         for (int i = 0; i < PHASE_TICKS; i++) begin
            // Advance time, mostly by small steps
            pick = $urandom_range(0, 99);
            if (pick < 70)      tick_ms = tick_ms + $urandom_range(0, 30);
            else if (pick < 90) tick_ms = tick_ms + $urandom_range(31, 1200);
            else if (pick < 96) tick_ms = tick_ms + $urandom_range(1201, 25000);
            else                tick_ms = $urandom;
            // Heartbeat age: mostly fresh, some at the boundary, some stale
            pick = $urandom_range(0, 99);
            if (pick < 65)      age = $urandom_range(0, link_limit);
            else if (pick < 80) age = link_limit + $urandom_range(0, 1);
            else if (pick < 92) age = link_limit + 1 + $urandom_range(0, 5000);
            else                age = $urandom;
            send_tick(tick_ms, tick_ms - age, $urandom_range(0, 3) == 0);
            if (i % 20 == 19) send_burst = ($urandom_range(0, 2) == 0);
         end
      end

      // Drain and give the verdict
      req_push <= 1'b0;
      do @(posedge clock); while (slots_owed != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d ticks and %0d slot responses under timeouts 0, 3000, 65535",
               ticks_sent, slots_seen);
      $display("and random values, with time wrap, stale heartbeats and a full stall.");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Pop responses after random stalls; hold off once for a long stretch
   initial begin : drain
      int   gap;
      int   taken;
      logic pop_burst;
      logic held;
      taken     = 0;
      pop_burst = 1'b0;
      held      = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = pop_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (!held && ticks_sent >= HOLD_TICK) begin
            gap  = HOLD_CYCLES;
            held = 1'b1;
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         taken++;
         if (taken % 40 == 0) pop_burst = ($urandom_range(0, 2) == 0);
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Watchdog: no request or response moved for %0d cycles", WATCHDOG_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

endmodule
